>>> rtl/lamm_pkg.sv
`timescale 1ns / 1ps
package lamm_pkg;

  // Cascade limits
  localparam int MaxRes    = 5;
  localparam int NumChecks = 4;
  localparam int SpW       = $clog2(MaxRes + 1);
  localparam int ChkIdxW   = $clog2(NumChecks + 1);
  localparam int ChkSelW   = $clog2(NumChecks);

  // Front queue depth
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Mux machine states
  localparam logic [2:0] MUX_BEGIN      = 3'd0;
  localparam logic [2:0] MUX_DETACHED   = 3'd1;
  localparam logic [2:0] MUX_WAITING    = 3'd2;
  localparam logic [2:0] MUX_ATTACHED   = 3'd3;
  localparam logic [2:0] MUX_COLLECTING = 3'd4;
  localparam logic [2:0] MUX_COLL_DIST  = 3'd5;
  localparam logic [2:0] MUX_KEEP       = 3'd7;

  // Event codes (E1..E9)
  localparam logic [3:0] EV_SELECTED   = 4'd0;
  localparam logic [3:0] EV_UNSELECTED = 4'd1;
  localparam logic [3:0] EV_SEL_READY  = 4'd2;
  localparam logic [3:0] EV_STANDBY    = 4'd3;
  localparam logic [3:0] EV_PSYNC      = 4'd4;
  localparam logic [3:0] EV_PNOSYNC    = 4'd5;
  localparam logic [3:0] EV_BEGIN      = 4'd6;
  localparam logic [3:0] EV_PCOLL      = 4'd7;
  localparam logic [3:0] EV_PNOCOLL    = 4'd8;

  // Selection codes
  localparam logic [1:0] SEL_SELECTED   = 2'd0;
  localparam logic [1:0] SEL_UNSELECTED = 2'd1;
  localparam logic [1:0] SEL_STANDBY    = 2'd2;

  typedef struct packed {
    logic [3:0] mode;
    logic [1:0] selection;
    logic       aggregator_present;
    logic       aggregator_ready;
    logic       partner_sync;
    logic       partner_collecting;
  } lamm_in_t;

  typedef struct packed {
    logic [2:0] new_state;
    logic       changed;
    logic       actor_sync;
    logic       actor_collecting;
    logic       actor_distributing;
    logic       attach_request;
    logic       detach_request;
    logic       disable_cd_request;
    logic       enable_collect_request;
    logic       enable_distribute_request;
    logic       wait_timer_start;
    logic       last;
  } lamm_out_t;

  // Classified item as held in the front queue
  typedef struct packed {
    logic [3:0] ev;
    logic       sel;
    logic       unsel;
    logic       stby;
    logic       present;
    logic       agg_ready;
    logic       psync;
    logic       pcoll;
  } lamm_cls_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_RUN
  } eng_state_t;

  // Event/state transition table; MUX_KEEP means no transition
  function automatic logic [2:0] mux_next(input logic [3:0] ev, input logic [2:0] st);
    logic [2:0] nxt;
    nxt = MUX_KEEP;
    case (ev)
      EV_SELECTED: begin
        if (st == MUX_DETACHED) nxt = MUX_WAITING;
      end
      EV_UNSELECTED: begin
        if (st == MUX_WAITING || st == MUX_ATTACHED) nxt = MUX_DETACHED;
        else if (st == MUX_COLLECTING || st == MUX_COLL_DIST) nxt = MUX_ATTACHED;
      end
      EV_SEL_READY: begin
        if (st == MUX_WAITING) nxt = MUX_ATTACHED;
      end
      EV_STANDBY: begin
        if (st == MUX_ATTACHED) nxt = MUX_DETACHED;
        else if (st == MUX_COLLECTING || st == MUX_COLL_DIST) nxt = MUX_ATTACHED;
      end
      EV_PSYNC: begin
        if (st == MUX_ATTACHED) nxt = MUX_COLLECTING;
      end
      EV_PNOSYNC, EV_PNOCOLL: begin
        if (st == MUX_COLLECTING || st == MUX_COLL_DIST) nxt = MUX_ATTACHED;
      end
      EV_BEGIN: begin
        if (st <= MUX_COLL_DIST) nxt = MUX_DETACHED;
      end
      EV_PCOLL: begin
        if (st == MUX_COLLECTING) nxt = MUX_COLL_DIST;
      end
      default: nxt = MUX_KEEP;
    endcase
    return nxt;
  endfunction

endpackage

>>> rtl/lamm_front.sv
`timescale 1ns / 1ps
module lamm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lamm_pkg::lamm_in_t  in_data,
  output logic                q_valid,
  output lamm_pkg::lamm_cls_t q_data,
  input  logic                q_pop
);
  import lamm_pkg::*;

  lamm_cls_t              mem_r [QDepth];
  logic [QPtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]       cnt_r;
  lamm_cls_t              cls;
  logic                   push, pop;

  // Classify the incoming item
  always_comb begin
    cls.ev        = in_data.mode;
    cls.sel       = (in_data.selection == SEL_SELECTED);
    cls.unsel     = (in_data.selection == SEL_UNSELECTED);
    cls.stby      = (in_data.selection == SEL_STANDBY);
    cls.present   = in_data.aggregator_present;
    cls.agg_ready = in_data.aggregator_ready;
    cls.psync     = in_data.partner_sync;
    cls.pcoll     = in_data.partner_collecting;
  end

  assign in_ready = (cnt_r != QCntW'(QDepth));
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Pointer wrap
  assign wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;

  // Queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop) rd_ptr_r <= rd_ptr_nxt;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= cls;
  end

endmodule

>>> rtl/lamm_back.sv
`timescale 1ns / 1ps
module lamm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lamm_pkg::lamm_cls_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lamm_pkg::lamm_out_t out_data
);
  import lamm_pkg::*;

  eng_state_t           eng_r, eng_nxt;
  logic [2:0]           cur_r;
  logic                 sync_r, coll_r, dist_r;
  lamm_cls_t            cond_r, cond_use;

  // Frame stack: state entered and next exit check to try
  logic [2:0]           frame_kind_r [MaxRes];
  logic [ChkIdxW-1:0]   frame_idx_r  [MaxRes];
  logic [SpW-1:0]       sp_r, top, push_at;
  logic [SpW-1:0]       res_cnt_r;

  lamm_out_t            pend_r, out_r;
  logic                 out_valid_r;

  logic [2:0]           top_kind;
  logic [ChkIdxW-1:0]   top_idx;
  logic [3:0]           chk_ev [NumChecks];
  logic [NumChecks-1:0] chk_cond, hit;
  logic                 hit_any;
  logic [ChkSelW-1:0]   hit_sel;

  logic [3:0]           step_ev;
  logic [2:0]           step_nxt;
  logic                 step_go;
  lamm_out_t            act_res, idle_res, emit_data;
  logic                 act_sync, act_coll, act_dist;

  logic                 out_free, room;
  logic                 do_trans, do_unwind, do_finish, emit_en;

  assign out_free = !out_valid_r || out_ready;
  assign room     = (res_cnt_r < SpW'(MaxRes));
  assign top      = (sp_r == '0) ? '0 : sp_r - 1'b1;
  assign push_at  = (eng_r == ENG_IDLE) ? '0 : sp_r;
  assign top_kind = frame_kind_r[top];
  assign top_idx  = frame_idx_r[top];

  // Exit checks of the state on top of the stack, in order
  always_comb begin
    for (int k = 0; k < NumChecks; k++) begin
      chk_ev[k]   = EV_BEGIN;
      chk_cond[k] = 1'b0;
    end
    case (top_kind)
      MUX_DETACHED: begin
        chk_ev[0] = EV_SELECTED;   chk_cond[0] = cond_r.sel;
        chk_ev[1] = EV_STANDBY;    chk_cond[1] = cond_r.stby;
      end
      MUX_WAITING: begin
        chk_ev[0] = EV_UNSELECTED; chk_cond[0] = cond_r.unsel;
        chk_ev[1] = EV_SEL_READY;
        chk_cond[1] = cond_r.sel && cond_r.present && cond_r.agg_ready;
      end
      MUX_ATTACHED: begin
        chk_ev[0] = EV_UNSELECTED; chk_cond[0] = cond_r.unsel;
        chk_ev[1] = EV_STANDBY;    chk_cond[1] = cond_r.stby;
        chk_ev[2] = EV_PSYNC;      chk_cond[2] = cond_r.psync && cond_r.sel;
      end
      MUX_COLLECTING: begin
        chk_ev[0] = EV_UNSELECTED; chk_cond[0] = cond_r.unsel;
        chk_ev[1] = EV_STANDBY;    chk_cond[1] = cond_r.stby;
        chk_ev[2] = EV_PNOSYNC;    chk_cond[2] = !cond_r.psync;
        chk_ev[3] = EV_PCOLL;
        chk_cond[3] = cond_r.sel && cond_r.psync && cond_r.pcoll && coll_r;
      end
      MUX_COLL_DIST: begin
        chk_ev[0] = EV_UNSELECTED; chk_cond[0] = cond_r.unsel;
        chk_ev[1] = EV_STANDBY;    chk_cond[1] = cond_r.stby;
        chk_ev[2] = EV_PNOSYNC;    chk_cond[2] = !cond_r.psync;
        chk_ev[3] = EV_PNOCOLL;    chk_cond[3] = cond_r.psync && !cond_r.pcoll;
      end
      default: ;
    endcase
  end

  // First remaining check that holds and moves the state
  always_comb begin
    for (int k = 0; k < NumChecks; k++) begin
      hit[k] = chk_cond[k] && (ChkIdxW'(k) >= top_idx) &&
               (mux_next(chk_ev[k], cur_r) != MUX_KEEP);
    end
    hit_any = |hit;
    hit_sel = '0;
    for (int k = NumChecks - 1; k >= 0; k--) begin
      if (hit[k]) hit_sel = ChkSelW'(k);
    end
  end

  // Shared transition unit: table lookup and entry action
  assign step_ev  = (eng_r == ENG_IDLE) ? q_data.ev : chk_ev[hit_sel];
  assign cond_use = (eng_r == ENG_IDLE) ? q_data : cond_r;
  assign step_nxt = mux_next(step_ev, cur_r);
  assign step_go  = (step_nxt != MUX_KEEP);

  always_comb begin
    act_sync = sync_r;
    act_coll = coll_r;
    act_dist = dist_r;
    act_res  = '0;
    case (step_nxt)
      MUX_DETACHED: begin
        act_sync = 1'b0; act_coll = 1'b0; act_dist = 1'b0;
        act_res.detach_request     = cond_use.present;
        act_res.disable_cd_request = 1'b1;
      end
      MUX_WAITING: begin
        act_res.wait_timer_start = 1'b1;
      end
      MUX_ATTACHED: begin
        act_sync = 1'b1; act_coll = 1'b0; act_dist = 1'b0;
        // no re-attach when falling back from collecting
        act_res.attach_request = cond_use.present && (cur_r != MUX_COLLECTING) &&
                                 (cur_r != MUX_COLL_DIST);
        act_res.disable_cd_request = 1'b1;
      end
      MUX_COLLECTING: begin
        act_coll = 1'b1; act_dist = 1'b0;
        act_res.enable_collect_request = 1'b1;
      end
      MUX_COLL_DIST: begin
        act_dist = 1'b1;
        act_res.enable_distribute_request = 1'b1;
      end
      default: ;
    endcase
    act_res.new_state          = step_nxt;
    act_res.changed            = 1'b1;
    act_res.actor_sync         = act_sync;
    act_res.actor_collecting   = act_coll;
    act_res.actor_distributing = act_dist;
    act_res.last               = 1'b0;
  end

  // No-transition result
  always_comb begin
    idle_res                    = '0;
    idle_res.new_state          = cur_r;
    idle_res.actor_sync         = sync_r;
    idle_res.actor_collecting   = coll_r;
    idle_res.actor_distributing = dist_r;
    idle_res.last               = 1'b1;
  end

  // Engine next state
  always_comb begin
    eng_nxt = eng_r;
    case (eng_r)
      ENG_IDLE: if (do_trans) eng_nxt = ENG_RUN;
      ENG_RUN:  if (do_finish) eng_nxt = ENG_IDLE;
      default:  eng_nxt = ENG_IDLE;
    endcase
  end

  // Engine controls
  always_comb begin
    q_pop     = 1'b0;
    do_trans  = 1'b0;
    do_unwind = 1'b0;
    do_finish = 1'b0;
    emit_en   = 1'b0;
    emit_data = idle_res;
    case (eng_r)
      ENG_IDLE: begin
        q_pop     = q_valid && out_free;
        do_trans  = q_pop && step_go;
        emit_en   = q_pop && !step_go;
      end
      ENG_RUN: begin
        emit_data = pend_r;
        if (out_free) begin
          if (hit_any && room) begin
            do_trans = 1'b1;
            emit_en  = 1'b1;
          end else if (!hit_any && room && sp_r > SpW'(1)) begin
            do_unwind = 1'b1;
          end else begin
            do_finish      = 1'b1;
            emit_en        = 1'b1;
            emit_data.last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_r       <= ENG_IDLE;
      cur_r       <= MUX_BEGIN;
      sync_r      <= 1'b0;
      coll_r      <= 1'b0;
      dist_r      <= 1'b0;
      sp_r        <= '0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      eng_r <= eng_nxt;
      if (do_trans) begin
        cur_r     <= step_nxt;
        sync_r    <= act_sync;
        coll_r    <= act_coll;
        dist_r    <= act_dist;
        sp_r      <= push_at + 1'b1;
        res_cnt_r <= (eng_r == ENG_IDLE) ? SpW'(1) : res_cnt_r + 1'b1;
      end else if (do_unwind) begin
        sp_r <= sp_r - 1'b1;
      end else if (do_finish) begin
        sp_r      <= '0;
        res_cnt_r <= '0;
      end
      if (emit_en) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) cond_r <= q_data;
    if (do_trans) begin
      pend_r                <= act_res;
      frame_kind_r[push_at] <= step_nxt;
      frame_idx_r[push_at]  <= '0;
      if (eng_r == ENG_RUN) frame_idx_r[top] <= ChkIdxW'(hit_sel) + 1'b1;
    end
    if (emit_en) out_r <= emit_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/link_aggregation_mux_machine_top.sv
`timescale 1ns / 1ps
// Link aggregation mux machine for one port.
// Input channel in_valid/in_ready/in_data: one event with the port's current
// selection, aggregator and partner conditions. Result channel
// out_valid/out_ready/out_data: one item per state transition (up to five per
// event), or one unchanged item when the event moves nothing; last marks the
// final item of an event.
// A two-entry front queue takes events while the engine works, so an event is
// accepted even while a result waits on the output register.
// Flow: an event is registered in the front queue before it reaches the
// engine. Popping an event takes its first transition; the engine then either
// takes the next transition, unwinds one nested entry with nothing left to
// check, or finishes with the last item, doing one table lookup per cycle while
// the output is free. A no-transition event is finished when it is popped.
// Reset (rst_n low, synchronous) puts the machine in the begin state with all
// actor flags clear and empties the queue and output register.
// When a result waits and out_ready is low the engine holds, then the queue
// fills and in_ready drops; no item is lost or repeated.
module link_aggregation_mux_machine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lamm_pkg::lamm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lamm_pkg::lamm_out_t out_data
);
  import lamm_pkg::*;

  logic      q_valid;
  lamm_cls_t q_data;
  logic      q_pop;

  // Accept and classify
  lamm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // Transition cascade and result output
  lamm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
